### sv/yfg_pkg.sv
// ----------------------------------------------------------------------------
// yfg_pkg
// Shared types and constants for the Yee-staggered bilinear field gather.
// ----------------------------------------------------------------------------
package yfg_pkg;

  // Six field grids: Ex, Ey, Ez, Hx, Hy, Hz.
  localparam int NCOMP = 6;

  // Fixed widths of the item fields.
  localparam int POS_W    = 18;
  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 16;

  // Function codes of an input item.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_GATHER = 1'b1;

  // Yee staggering per component: a set bit means a whole-cell offset on
  // that axis, a clear bit means a half-cell offset.
  localparam logic [NCOMP-1:0] X_FULL = 6'b110001;
  localparam logic [NCOMP-1:0] Y_FULL = 6'b101010;

  // Banks per grid, selected by the parity of the x and y index.
  localparam int NBANK = 4;

  typedef logic [1:0] bank_sel_t;

endpackage

### sv/yee_field_gather_bilinear.sv
// A gather item is registered through stages 1, 2 and 3 and then the output register.
// Throughput: one item per cycle while no result is held by out_stall; each grid is split
// into four banks by index parity, so the four corners of every component are read together.
// A write item is stored in the cycle it is accepted and gives no result.
// Reset (rst_n low, synchronous) clears the pipeline valid bits only; grid
// contents are undefined until written.
// ----------------------------------------------------------------------------
// yee_field_gather_bilinear
// Six staggered 2D field grids with a pipelined bilinear gather of all six
// components at a particle position.
// ----------------------------------------------------------------------------
module yee_field_gather_bilinear
  import yfg_pkg::*;
#(
  parameter int GRID_X     = 64,
  parameter int GRID_Y     = 64,
  parameter int FRAC_BITS  = 12,
  parameter int FIELD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [2:0]                 in_component,
  input  logic [5:0]                 in_cell_x,
  input  logic [5:0]                 in_cell_y,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [POS_W-1:0]           in_pos_x,
  input  logic [POS_W-1:0]           in_pos_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_e_x,
  output logic signed [RESULT_W-1:0] out_e_y,
  output logic signed [RESULT_W-1:0] out_e_z,
  output logic signed [RESULT_W-1:0] out_h_x,
  output logic signed [RESULT_W-1:0] out_h_y,
  output logic signed [RESULT_W-1:0] out_h_z,
  output logic                       out_out_of_range
);

  // Derived sizes.
  localparam int XW   = $clog2(GRID_X);
  localparam int YW   = $clog2(GRID_Y);
  localparam int IW   = POS_W - FRAC_BITS;
  localparam int HX   = (GRID_X + 1) / 2;
  localparam int HY   = (GRID_Y + 1) / 2;
  localparam int BD   = HX * HY;
  localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int WW   = FRAC_BITS + 1;
  localparam int PW   = FIELD_BITS + WW + 1;
  localparam int ACCW = PW + 2;

  localparam logic [POS_W:0] HALF_FX = (POS_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [POS_W:0] ONE_FX  = (POS_W + 1)'(1) << FRAC_BITS;
  localparam logic [WW-1:0]  ONE_W   = WW'(1) << FRAC_BITS;

  // Pipeline advance: the whole pipe moves unless a result is held.
  logic adv;
  logic in_acc;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // --------------------------------------------------------------------------
  // Grid writes: the item is stored in the bank chosen by index parity.
  // --------------------------------------------------------------------------
  logic                  wr_ok;
  bank_sel_t             wr_bank;
  logic [BAW-1:0]        wr_addr;
  logic [FIELD_BITS-1:0] wr_data;

  always_comb begin
    int col;
    int row;
    col     = int'(in_cell_x) >> 1;
    row     = int'(in_cell_y) >> 1;
    wr_ok   = in_acc && (in_func == FUNC_WRITE) && (int'(in_component) < NCOMP)
              && (int'(in_cell_x) < GRID_X) && (int'(in_cell_y) < GRID_Y);
    wr_bank = {in_cell_y[0], in_cell_x[0]};
    wr_addr = BAW'(row * HX + col);
    wr_data = FIELD_BITS'(in_sample);
  end

  // --------------------------------------------------------------------------
  // Stage 1 input: cell index and fraction for both offsets on each axis.
  // --------------------------------------------------------------------------
  logic [POS_W:0]     ux [2];
  logic [POS_W:0]     uy [2];
  logic [XW-1:0]      ix_nxt [2];
  logic [YW-1:0]      iy_nxt [2];
  logic [FRAC_BITS-1:0] fx_nxt [2];
  logic [FRAC_BITS-1:0] fy_nxt [2];
  logic [1:0]         okx;
  logic [1:0]         oky;

  always_comb begin
    logic [IW-1:0] ixf;
    logic [IW-1:0] iyf;
    for (int v = 0; v < 2; v++) begin
      ux[v]     = {1'b0, in_pos_x} - ((v == 0) ? HALF_FX : ONE_FX);
      uy[v]     = {1'b0, in_pos_y} - ((v == 0) ? HALF_FX : ONE_FX);
      ixf       = ux[v][POS_W-1:FRAC_BITS];
      iyf       = uy[v][POS_W-1:FRAC_BITS];
      okx[v]    = !ux[v][POS_W] && ((int'(ixf) + 1) < GRID_X);
      oky[v]    = !uy[v][POS_W] && ((int'(iyf) + 1) < GRID_Y);
      ix_nxt[v] = XW'(ixf);
      iy_nxt[v] = YW'(iyf);
      fx_nxt[v] = ux[v][FRAC_BITS-1:0];
      fy_nxt[v] = uy[v][FRAC_BITS-1:0];
    end
  end

  logic                 v1_r;
  logic                 oor1_r;
  logic [XW-1:0]        ix1_r [2];
  logic [YW-1:0]        iy1_r [2];
  logic [FRAC_BITS-1:0] fx1_r [2];
  logic [FRAC_BITS-1:0] fy1_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_acc && (in_func == FUNC_GATHER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor1_r <= !(&okx && &oky);
      ix1_r  <= ix_nxt;
      iy1_r  <= iy_nxt;
      fx1_r  <= fx_nxt;
      fy1_r  <= fy_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: bank read addresses per component and corner weights.
  // --------------------------------------------------------------------------
  logic [BAW-1:0] rd_addr [NCOMP][NBANK];
  logic [NCOMP-1:0] px_nxt;
  logic [NCOMP-1:0] py_nxt;

  always_comb begin
    logic [XW-1:0] ix;
    logic [YW-1:0] iy;
    int col;
    int row;
    for (int c = 0; c < NCOMP; c++) begin
      ix        = ix1_r[X_FULL[c]];
      iy        = iy1_r[Y_FULL[c]];
      px_nxt[c] = ix[0];
      py_nxt[c] = iy[0];
      for (int b = 0; b < NBANK; b++) begin
        // Even bank holds the even corner, which is one up when the index is odd.
        col = (b % 2 == 1) ? (int'(ix) >> 1) : ((int'(ix) + 1) >> 1);
        row = (b / 2 == 1) ? (int'(iy) >> 1) : ((int'(iy) + 1) >> 1);
        rd_addr[c][b] = BAW'(row * HX + col);
      end
    end
  end

  logic [WW-1:0] wgt_nxt [2][2][4];

  always_comb begin
    logic [WW-1:0]   wx;
    logic [WW-1:0]   wy;
    logic [2*WW-1:0] prod;
    for (int vx = 0; vx < 2; vx++) begin
      for (int vy = 0; vy < 2; vy++) begin
        for (int k = 0; k < 4; k++) begin
          wx   = (k % 2 == 1) ? {1'b0, fx1_r[vx]} : (ONE_W - {1'b0, fx1_r[vx]});
          wy   = (k / 2 == 1) ? {1'b0, fy1_r[vy]} : (ONE_W - {1'b0, fy1_r[vy]});
          prod = wx * wy;
          wgt_nxt[vx][vy][k] = WW'(prod >> FRAC_BITS);
        end
      end
    end
  end

  logic                  v2_r;
  logic                  oor2_r;
  logic [NCOMP-1:0]      px2_r;
  logic [NCOMP-1:0]      py2_r;
  logic [WW-1:0]         wgt2_r [2][2][4];
  logic [FIELD_BITS-1:0] rd_data [NCOMP][NBANK];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor2_r <= oor1_r;
      px2_r  <= px_nxt;
      py2_r  <= py_nxt;
      wgt2_r <= wgt_nxt;
    end
  end

  // Field memories: one bank per component and index parity.
  for (genvar gc = 0; gc < NCOMP; gc++) begin : g_comp
    for (genvar gb = 0; gb < NBANK; gb++) begin : g_bank
      yfg_ram #(
        .WIDTH (FIELD_BITS),
        .DEPTH (BD)
      ) u_ram (
        .clk     (clk),
        .wr_en   (wr_ok && (int'(in_component) == gc) && (int'(wr_bank) == gb)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr[gc][gb]),
        .rd_data (rd_data[gc][gb])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: route banks to corners and weight each sample.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod_nxt [NCOMP][4];

  always_comb begin
    bank_sel_t     bsel;
    logic [WW-1:0] w;
    for (int c = 0; c < NCOMP; c++) begin
      for (int k = 0; k < 4; k++) begin
        bsel = {py2_r[c] ^ (k / 2 == 1), px2_r[c] ^ (k % 2 == 1)};
        w    = wgt2_r[X_FULL[c]][Y_FULL[c]][k];
        prod_nxt[c][k] = $signed(rd_data[c][bsel]) * $signed({1'b0, w});
      end
    end
  end

  logic                 v3_r;
  logic                 oor3_r;
  logic signed [PW-1:0] prod3_r [NCOMP][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor3_r  <= oor2_r;
      prod3_r <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum the corners, floor-shift and zero the item when out of range.
  // --------------------------------------------------------------------------
  logic [RESULT_W-1:0] res_nxt [NCOMP];

  always_comb begin
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] sh;
    for (int c = 0; c < NCOMP; c++) begin
      acc = ACCW'(prod3_r[c][0]) + ACCW'(prod3_r[c][1])
          + ACCW'(prod3_r[c][2]) + ACCW'(prod3_r[c][3]);
      sh  = acc >>> FRAC_BITS;
      res_nxt[c] = oor3_r ? '0 : sh[RESULT_W-1:0];
    end
  end

  logic                out_valid_r;
  logic                out_oor_r;
  logic [RESULT_W-1:0] out_res_r [NCOMP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_oor_r <= oor3_r;
      out_res_r <= res_nxt;
    end
  end

  // Result ports.
  assign out_valid        = out_valid_r;
  assign out_out_of_range = out_oor_r;
  assign out_e_x          = $signed(out_res_r[0]);
  assign out_e_y          = $signed(out_res_r[1]);
  assign out_e_z          = $signed(out_res_r[2]);
  assign out_h_x          = $signed(out_res_r[3]);
  assign out_h_y          = $signed(out_res_r[4]);
  assign out_h_z          = $signed(out_res_r[5]);

endmodule

### sv/yfg_ram.sv
// ----------------------------------------------------------------------------
// yfg_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module yfg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read; a read at the address being written returns old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
